FILE: rtl/twc_pkg.sv
// twc_pkg: shared types, constants and handshake structs for the two-way cache tag store
// no dependencies; used by twc_ctrl, twc_datapath and the top level
package twc_pkg;

  // default geometry
  localparam int BLOCK_BYTES_DEF = 32;
  localparam int CACHE_BYTES_DEF = 16384;
  localparam int ADDR_BITS_DEF   = 32;

  // access mode codes
  localparam logic [1:0] MODE_PROBE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // input word
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [31:0] write_value;
    logic        way;
    logic        mark_dirty;
  } in_t;

  // result word
  typedef struct packed {
    logic        hit;
    logic        hit_way;
    logic        hit_dirty;
    logic        lru_way;
    logic        has_free_way;
    logic        free_way;
    logic [31:0] victim_address;
    logic [31:0] read_word;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic load_in;
    logic mem_read;
    logic lookup;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/twc_ctrl.sv
// twc_ctrl: sequencer for the cache tag store, runs the clearing pass and the access steps
// depends on twc_pkg (cmd_t, sts_t)
module twc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  twc_pkg::sts_t sts,
  output twc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOOKUP,
    ST_DATA
  } state_t;

  state_t state;

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.clear_step = (state == ST_CLEAR);
    cmd.load_in    = (state == ST_IDLE) && in_valid;
    cmd.mem_read   = (state == ST_READ);
    cmd.lookup     = (state == ST_LOOKUP);
    cmd.load_out   = (state == ST_DATA) && sts.out_free;
  end

  // state and ready register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      in_ready <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (sts.clear_done) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state    <= ST_READ;
            in_ready <= 1'b0;
          end
        end
        ST_READ: begin
          state <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          state <= ST_DATA;
        end
        ST_DATA: begin
          if (sts.out_free) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_CLEAR;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/twc_datapath.sv
// twc_datapath: set metadata, tag and data memories, tag compare and result register
// depends on twc_pkg (in_t, out_t, cmd_t, sts_t, mode codes)
module twc_datapath #(
  parameter int BLOCK_BYTES = twc_pkg::BLOCK_BYTES_DEF,
  parameter int CACHE_BYTES = twc_pkg::CACHE_BYTES_DEF,
  parameter int ADDR_BITS   = twc_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  twc_pkg::cmd_t  cmd,
  output twc_pkg::sts_t  sts,
  input  twc_pkg::in_t   in_data,
  output twc_pkg::out_t  out_data,
  output logic           out_valid,
  input  logic           out_ready
);

  localparam int NUM_SETS  = CACHE_BYTES / (2 * BLOCK_BYTES);
  localparam int WPB       = BLOCK_BYTES / 4;
  localparam int NUM_WORDS = NUM_SETS * 2 * WPB;
  localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int WORD_BITS = $clog2(WPB);
  localparam int LOW_BITS  = OFF_BITS + SET_BITS;
  localparam int TAG_RAW   = ADDR_BITS - LOW_BITS;
  localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int DIDX_W    = $clog2(NUM_WORDS);
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [31:0] LOW_MASK  = 32'((64'd1 << LOW_BITS) - 64'd1);
  localparam logic [31:0] SET_MASK  = 32'(NUM_SETS - 1);
  localparam logic [31:0] WORD_MASK = 32'(WPB - 1);

  typedef struct packed {
    logic lru;
    logic valid1;
    logic dirty1;
    logic valid0;
    logic dirty0;
  } meta_t;

  // storage
  meta_t              meta_mem [NUM_SETS];
  logic [TAG_W-1:0]   tag0_mem [NUM_SETS];
  logic [TAG_W-1:0]   tag1_mem [NUM_SETS];
  logic [31:0]        data_mem [NUM_WORDS];

  twc_pkg::in_t       req;
  meta_t              meta_q;
  logic [TAG_W-1:0]   tag0_q;
  logic [TAG_W-1:0]   tag1_q;
  logic [31:0]        rdata_q;
  twc_pkg::out_t      res;
  logic [SET_W-1:0]   clr_idx;

  logic [31:0]        addr_m;
  logic [SET_W-1:0]   set_idx;
  logic [TAG_W-1:0]   tag_cur;
  logic [DIDX_W-1:0]  word_idx;
  logic [DIDX_W-1:0]  rd_idx;
  logic [DIDX_W-1:0]  wr_idx;
  logic               is_read;
  logic               is_write;
  logic               h0;
  logic               h1;
  logic [TAG_W-1:0]   vtag;
  meta_t              meta_upd;
  twc_pkg::out_t      res_next;
  twc_pkg::out_t      out_next;

  // address split
  always_comb begin
    addr_m   = req.address & ADDR_MASK;
    set_idx  = SET_W'((addr_m >> OFF_BITS) & SET_MASK);
    tag_cur  = TAG_W'(addr_m >> LOW_BITS);
    word_idx = DIDX_W'((addr_m >> 2) & WORD_MASK);
    is_read  = (req.mode == twc_pkg::MODE_READ);
    is_write = (req.mode == twc_pkg::MODE_WRITE);
  end

  // tag compare and probe results
  always_comb begin
    h0   = meta_q.valid0 && (tag0_q == tag_cur);
    h1   = meta_q.valid1 && (tag1_q == tag_cur);
    vtag = req.way ? tag1_q : tag0_q;

    res_next                = '0;
    res_next.hit            = h0 || h1;
    res_next.hit_way        = !h0 && h1;
    res_next.hit_dirty      = h0 ? meta_q.dirty0 : (h1 ? meta_q.dirty1 : 1'b0);
    res_next.lru_way        = meta_q.lru;
    res_next.has_free_way   = !meta_q.valid0 || !meta_q.valid1;
    res_next.free_way       = meta_q.valid0 && !meta_q.valid1;
    res_next.victim_address = ((32'(vtag) << LOW_BITS) | (addr_m & LOW_MASK)) & ADDR_MASK;
    res_next.read_word      = '0;

    rd_idx = (DIDX_W'(set_idx) << (WORD_BITS + 1)) | (DIDX_W'(!h0) << WORD_BITS) | word_idx;
    wr_idx = (DIDX_W'(set_idx) << (WORD_BITS + 1)) | (DIDX_W'(req.way) << WORD_BITS)
             | word_idx;
  end

  // metadata update for read and write
  always_comb begin
    meta_upd = meta_q;
    if (is_read) begin
      meta_upd.lru = h0;
    end else if (is_write) begin
      meta_upd.lru = !req.way;
      if (req.way) begin
        meta_upd.valid1 = 1'b1;
        meta_upd.dirty1 = req.mark_dirty;
      end else begin
        meta_upd.valid0 = 1'b1;
        meta_upd.dirty0 = req.mark_dirty;
      end
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req <= in_data;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_step && !sts.clear_done) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // metadata memory
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      meta_mem[clr_idx] <= '0;
    end else if (cmd.lookup && (is_read || is_write)) begin
      meta_mem[set_idx] <= meta_upd;
    end
    if (cmd.mem_read) begin
      meta_q <= meta_mem[set_idx];
    end
  end

  // tag memories
  always_ff @(posedge clk) begin
    if (cmd.lookup && is_write && !req.way) begin
      tag0_mem[set_idx] <= tag_cur;
    end
    if (cmd.mem_read) begin
      tag0_q <= tag0_mem[set_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup && is_write && req.way) begin
      tag1_mem[set_idx] <= tag_cur;
    end
    if (cmd.mem_read) begin
      tag1_q <= tag1_mem[set_idx];
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (cmd.lookup && is_write) begin
      data_mem[wr_idx] <= req.write_value;
    end
    if (cmd.lookup) begin
      rdata_q <= data_mem[rd_idx];
    end
  end

  // probe result register
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      res <= res_next;
    end
  end

  // result word with the read data merged in
  always_comb begin
    out_next           = res;
    out_next.read_word = is_read ? rdata_q : 32'd0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= out_next;
    end
  end

  // status
  always_comb begin
    sts.clear_done = (clr_idx == SET_W'(NUM_SETS - 1));
    sts.out_free   = !out_valid || out_ready;
  end

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while stalled");

  // a loaded result is offered in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not offered");

  // dirty mark only reported with a hit
  a_dirty_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |=> (!res.hit_dirty || res.hit))
    else $error("dirty mark reported on a miss");

  // no access steps while the clearing pass runs
  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !(cmd.load_in || cmd.mem_read || cmd.lookup || cmd.load_out))
    else $error("access step during clearing pass");

endmodule

FILE: rtl/two_way_cache_tag_store_unit.sv
// two_way_cache_tag_store_unit: two-way set-associative write-back cache array, one lru bit a set
// steps are accept, set memory read, compare/update, output load; an output stall holds the result
// a new word is accepted only once the last result word is loaded into the output register
// reset: valid, dirty and lru bits are cleared by a pass of one set a cycle (cache bytes
// divided by twice the block bytes, 256 sets by default); in_ready stays low until it ends
// depends on twc_pkg, twc_ctrl, twc_datapath
module two_way_cache_tag_store_unit #(
  parameter int BLOCK_BYTES = twc_pkg::BLOCK_BYTES_DEF,
  parameter int CACHE_BYTES = twc_pkg::CACHE_BYTES_DEF,
  parameter int ADDR_BITS   = twc_pkg::ADDR_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  twc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output twc_pkg::out_t out_data
);

  twc_pkg::cmd_t cmd;
  twc_pkg::sts_t sts;

  // sequencer
  twc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memories and compare logic
  twc_datapath #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .CACHE_BYTES (CACHE_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
